@@ src/assert_macros.svh @@
// Assertion macros for the Poly1305 RTL.
// No dependencies; included by poly1305_mac, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/p1305_pkg.sv @@
// Shared types and constants for the Poly1305 authenticator.
// No dependencies.
package p1305_pkg;

	localparam int LIMB_W = 32;
	localparam int WORD_W = 64;
	localparam int BLK_BYTES = 16;

	typedef enum logic [1:0] {
		REG_R_LOW  = 2'd0,
		REG_R_HIGH = 2'd1,
		REG_S_LOW  = 2'd2,
		REG_S_HIGH = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_FIN1,
		ST_FIN2
	} state_t;

	typedef struct packed {
		logic       take;
		logic       mul_go;
		logic [1:0] mul_idx;
		logic       sum_go;
		logic [1:0] sum_idx;
		logic       red_go;
		logic [1:0] red_idx;
		logic       fin1;
		logic       load;
	} cmd_t;

	typedef struct packed {
		logic nonempty;
		logic last;
	} stat_t;

endpackage

@@ src/p1305_cfg_if.sv @@
// Key register write channel.
// Depends on p1305_pkg.
interface p1305_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    index;
	logic [p1305_pkg::WORD_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/p1305_in_if.sv @@
// Message block channel.
// Depends on p1305_pkg.
interface p1305_in_if;
	logic                          valid;
	logic                          ready;
	logic [p1305_pkg::WORD_W-1:0]  data_low;
	logic [p1305_pkg::WORD_W-1:0]  data_high;
	logic [4:0]                    byte_count;
	logic                          last_block;

	modport source (output valid, data_low, data_high, byte_count, last_block, input ready);
	modport sink (input valid, data_low, data_high, byte_count, last_block, output ready);
endinterface

@@ src/p1305_out_if.sv @@
// Tag channel.
// Depends on p1305_pkg.
interface p1305_out_if;
	logic                          valid;
	logic                          ready;
	logic [p1305_pkg::WORD_W-1:0]  tag_low;
	logic [p1305_pkg::WORD_W-1:0]  tag_high;

	modport source (output valid, tag_low, tag_high, input ready);
	modport sink (input valid, tag_low, tag_high, output ready);
endinterface

@@ src/p1305_ctrl.sv @@
// Sequencer for the Poly1305 datapath: block intake, multiply, reduce, finalize.
// Depends on p1305_pkg.
module p1305_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  p1305_pkg::stat_t  stat,
	output p1305_pkg::cmd_t   cmd
);

	p1305_pkg::state_t state_q, state_nxt;
	logic [2:0] cnt_q, cnt_nxt;
	logic       last_q;
	logic       out_valid_q;
	logic       take;
	logic       slot_free;

	assign in_ready  = (state_q == p1305_pkg::ST_IDLE);
	assign take      = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		unique case (state_q)
			p1305_pkg::ST_IDLE: begin
				cnt_nxt = 3'd0;
				if (take) begin
					if (stat.nonempty)
						state_nxt = p1305_pkg::ST_MUL;
					else if (stat.last)
						state_nxt = p1305_pkg::ST_FIN1;
				end
			end
			p1305_pkg::ST_MUL: begin
				if (cnt_q == 3'd4) begin
					state_nxt = p1305_pkg::ST_RED;
					cnt_nxt   = 3'd0;
				end else begin
					cnt_nxt = cnt_q + 3'd1;
				end
			end
			p1305_pkg::ST_RED: begin
				if (cnt_q == 3'd3) begin
					state_nxt = last_q ? p1305_pkg::ST_FIN1 : p1305_pkg::ST_IDLE;
					cnt_nxt   = 3'd0;
				end else begin
					cnt_nxt = cnt_q + 3'd1;
				end
			end
			p1305_pkg::ST_FIN1: state_nxt = p1305_pkg::ST_FIN2;
			p1305_pkg::ST_FIN2: begin
				if (slot_free)
					state_nxt = p1305_pkg::ST_IDLE;
			end
			default: state_nxt = p1305_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.take    = take;
		cmd.mul_idx = cnt_q[1:0];
		cmd.sum_idx = 2'(cnt_q - 3'd1);
		cmd.red_idx = cnt_q[1:0];
		unique case (state_q)
			p1305_pkg::ST_MUL: begin
				cmd.mul_go = (cnt_q != 3'd4);
				cmd.sum_go = (cnt_q != 3'd0);
			end
			p1305_pkg::ST_RED:  cmd.red_go = 1'b1;
			p1305_pkg::ST_FIN1: cmd.fin1 = 1'b1;
			p1305_pkg::ST_FIN2: cmd.load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= p1305_pkg::ST_IDLE;
			cnt_q       <= 3'd0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (take)
				last_q <= stat.last;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/p1305_dp.sv @@
// Poly1305 datapath: key registers, accumulator, multiply lanes, reduction, tag.
// Depends on p1305_pkg.
module p1305_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [p1305_pkg::WORD_W-1:0] cfg_data,
	input  logic [p1305_pkg::WORD_W-1:0] data_low,
	input  logic [p1305_pkg::WORD_W-1:0] data_high,
	input  logic [4:0]                   byte_count,
	input  logic                         last_block,
	input  p1305_pkg::cmd_t              cmd,
	output p1305_pkg::stat_t             stat,
	output logic [p1305_pkg::WORD_W-1:0] tag_low,
	output logic [p1305_pkg::WORD_W-1:0] tag_high
);

	logic [63:0] key_r_low_q, key_r_high_q, key_s_low_q, key_s_high_q;
	logic [31:0] acc_q [5];

	logic [27:0] r0, r1, r2, r3;
	logic [28:0] rv [4];
	logic [28:0] fv [4];
	logic [1:0]  f4;

	logic [4:0]   nsat;
	logic [127:0] raw, blk;
	logic         hibit;

	logic [32:0] a_q [4];
	logic [31:0] a4_q;
	logic [32:0] a_op [5];
	logic [28:0] coef [5];
	logic [61:0] prod_w [5];
	logic [61:0] prod_s1 [5];
	logic [63:0] p_sum;
	logic [63:0] p_q [4];

	logic [33:0]  p4w;
	logic [31:0]  top;
	logic [1:0]   top_lo_q;
	logic [32:0]  top5;
	logic [63:0]  q;
	logic [31:0]  carry_q;

	logic [127:0] acc128, s128, tag_sum;
	logic [128:0] chk;
	logic [32:0]  hi_c;
	logic [33:0]  cf_q;

	assign stat.nonempty = (byte_count != 5'd0);
	assign stat.last     = last_block;

	// clamp r
	assign r0 = key_r_low_q[27:0];
	assign r1 = {key_r_low_q[59:34], 2'b00};
	assign r2 = {key_r_high_q[27:2], 2'b00};
	assign r3 = {key_r_high_q[59:34], 2'b00};
	assign rv[0] = 29'(r0);
	assign rv[1] = 29'(r1);
	assign rv[2] = 29'(r2);
	assign rv[3] = 29'(r3);
	assign fv[0] = 29'({r0[27:2], 2'b00}) + 29'(r0[27:2]);
	assign fv[1] = 29'(r1[27:2]) + 29'(r1);
	assign fv[2] = 29'(r2[27:2]) + 29'(r2);
	assign fv[3] = 29'(r3[27:2]) + 29'(r3);
	assign f4    = r0[1:0];

	// pad the block: bytes past the count drop, a 0x01 marks the end of a short block
	assign nsat  = byte_count[4] ? 5'd16 : byte_count;
	assign hibit = byte_count[4];
	assign raw   = {data_high, data_low};
	always_comb begin
		for (int b = 0; b < p1305_pkg::BLK_BYTES; b++) begin
			if (5'(b) < nsat)
				blk[8*b +: 8] = raw[8*b +: 8];
			else if (5'(b) == nsat)
				blk[8*b +: 8] = 8'h01;
			else
				blk[8*b +: 8] = 8'h00;
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++)
			a_op[j] = a_q[j];
		a_op[4] = {1'b0, a4_q};
		for (int j = 0; j < 5; j++) begin
			if (int'(cmd.mul_idx) >= j)
				coef[j] = rv[2'(int'(cmd.mul_idx) - j)];
			else
				coef[j] = fv[2'(4 + int'(cmd.mul_idx) - j)];
			prod_w[j] = a_op[j] * coef[j];
		end
	end

	assign p_sum = 64'(prod_s1[0]) + 64'(prod_s1[1]) + 64'(prod_s1[2])
		+ 64'(prod_s1[3]) + 64'(prod_s1[4]);

	assign p4w  = a4_q * f4;
	assign top  = p4w[31:0] + p_q[3][63:32];
	assign top5 = 33'({top[31:2], 2'b00}) + 33'(top[31:2]);

	always_comb begin
		case (cmd.red_idx)
			2'd0:    q = 64'(top5) + 64'(p_q[0][31:0]);
			2'd1:    q = 64'(carry_q) + 64'(p_q[1][31:0]) + 64'(p_q[0][63:32]);
			2'd2:    q = 64'(carry_q) + 64'(p_q[2][31:0]) + 64'(p_q[1][63:32]);
			default: q = 64'(carry_q) + 64'(p_q[3][31:0]) + 64'(p_q[2][63:32]);
		endcase
	end

	assign acc128  = {acc_q[3], acc_q[2], acc_q[1], acc_q[0]};
	assign s128    = {key_s_high_q, key_s_low_q};
	assign chk     = {1'b0, acc128} + 129'd5;
	assign hi_c    = {1'b0, acc_q[4]} + 33'(chk[128]);
	assign tag_sum = acc128 + s128 + 128'(cf_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_r_low_q  <= '0;
			key_r_high_q <= '0;
			key_s_low_q  <= '0;
			key_s_high_q <= '0;
			for (int i = 0; i < 5; i++)
				acc_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (p1305_pkg::cfg_reg_t'(cfg_index))
					p1305_pkg::REG_R_LOW:  key_r_low_q  <= cfg_data;
					p1305_pkg::REG_R_HIGH: key_r_high_q <= cfg_data;
					p1305_pkg::REG_S_LOW:  key_s_low_q  <= cfg_data;
					p1305_pkg::REG_S_HIGH: key_s_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.red_go) begin
				acc_q[cmd.red_idx] <= q[31:0];
				if (cmd.red_idx == 2'd3)
					acc_q[4] <= q[63:32] + 32'(top_lo_q);
			end
			if (cmd.load) begin
				for (int i = 0; i < 5; i++)
					acc_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int i = 0; i < 4; i++)
				a_q[i] <= {1'b0, acc_q[i]} + {1'b0, blk[32*i +: 32]};
			a4_q <= acc_q[4] + 32'(hibit);
		end
		if (cmd.mul_go) begin
			for (int j = 0; j < 5; j++)
				prod_s1[j] <= prod_w[j];
		end
		if (cmd.sum_go)
			p_q[cmd.sum_idx] <= p_sum;
		if (cmd.red_go) begin
			carry_q <= q[63:32];
			if (cmd.red_idx == 2'd0)
				top_lo_q <= top[1:0];
		end
		if (cmd.fin1)
			cf_q <= 34'({hi_c[32:2], 2'b00}) + 34'(hi_c[32:2]);
		if (cmd.load) begin
			tag_low  <= tag_sum[63:0];
			tag_high <= tag_sum[127:64];
		end
	end

endmodule

@@ src/poly1305_mac.sv @@
// Poly1305 one-time authenticator. Load r and s through cfg (index 0..3: r low, r high,
// s low, s high; r is clamped on use, the port is always ready). Feed message words on blk,
// 16 little-endian bytes each with a byte count and a last flag; only the last word may be
// short, and a short word is padded with a 0x01 byte. Each word with bytes is latched on
// acceptance, run on the five 33x29 multiply lanes (the four product columns are formed one
// per cycle and summed once registered) and through the partial reduction's carry chain, one
// limb a cycle, before ready returns. A last word then adds the final reduction and the s
// addition; once the output slot is free the tag is written to the output register and the
// accumulator clears. An empty last word goes straight to the final reduction, an empty
// middle word leaves the block ready. A new word is taken while a tag still waits on tag.
// Depends on p1305_pkg, the channel interfaces, p1305_ctrl, p1305_dp and assert_macros.svh.
`include "assert_macros.svh"

module poly1305_mac (
	input  logic              clk,
	input  logic              arst_n,
	p1305_cfg_if.sink         cfg,
	p1305_in_if.sink          blk,
	p1305_out_if.source       tag
);

	p1305_pkg::cmd_t  cmd;
	p1305_pkg::stat_t stat;
	logic             out_valid;
	logic             empty_mid;
	logic [4:0]       phase_vec;

	// key writes land at once; hold no backpressure
	assign cfg.ready = 1'b1;
	assign tag.valid = out_valid;

	p1305_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blk.valid),
		.in_ready  (blk.ready),
		.out_valid (out_valid),
		.out_ready (tag.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	p1305_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.data_low   (blk.data_low),
		.data_high  (blk.data_high),
		.byte_count (blk.byte_count),
		.last_block (blk.last_block),
		.cmd        (cmd),
		.stat       (stat),
		.tag_low    (tag.tag_low),
		.tag_high   (tag.tag_high)
	);

	assign empty_mid = blk.valid && blk.ready && blk.byte_count == 5'd0 && !blk.last_block;
	assign phase_vec = {cmd.take, cmd.mul_go, cmd.red_go, cmd.fin1, cmd.load};

	// a tag is only written into a free or draining output slot
	`AST_IMPLY(a_load_free, clk, arst_n, cmd.load, !out_valid || tag.ready, "tag overwrite")
	// an empty middle word leaves the block ready the next cycle
	`AST_NEXT(a_empty_skip, clk, arst_n, empty_mid, blk.ready, "empty word stalled")
	// a new tag appears only after a load
	`AST_IMPLY(a_out_src, clk, arst_n, $rose(tag.valid), $past(cmd.load), "tag without load")
	// datapath phases never overlap
	`AST_IMPLY(a_phase_excl, clk, arst_n, 1'b1, $onehot0(phase_vec), "phase overlap")

endmodule

@@ tb/tb_poly1305_mac.sv @@
// Self-checking testbench for the Poly1305 authenticator: table-driven directed words,
// then random messages, each tag checked against a behavioral predictor or a typed tag.
// Depends on p1305_pkg, poly1305_mac and the cfg, blk and tag channel interfaces.
module tb_poly1305_mac;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        last;
		logic        known;   // expected tag typed into the table
		logic [63:0] tlo;
		logic [63:0] thi;
	} blk_row_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} tag_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   n_words = 0;
	int   n_tags = 0;

	p1305_cfg_if cfg_ch ();
	p1305_in_if  blk_ch ();
	p1305_out_if tag_ch ();

	poly1305_mac u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.blk    (blk_ch),
		.tag    (tag_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: key copy and 130-bit accumulator kept as five 32-bit limbs
	logic [63:0] key_rl, key_rh, key_sl, key_sh;
	logic [31:0] acc [5];
	tag_word_t   pending_tags [$];

	// absorb one padded block; hibit is 1 for full 16-byte blocks
	function automatic void mac_absorb(logic [127:0] m, logic [31:0] hibit);
		logic [63:0] r0, r1, r2, r3, f0, f1, f2, f3, f4;
		logic [63:0] a0, a1, a2, a3, a4, p0, p1, p2, p3, q0, q1, q2, q3;
		logic [31:0] p4, top, q4;
		r0 = {32'b0, key_rl[31:0] & 32'h0fffffff};
		r1 = {32'b0, key_rl[63:32] & 32'h0ffffffc};
		r2 = {32'b0, key_rh[31:0] & 32'h0ffffffc};
		r3 = {32'b0, key_rh[63:32] & 32'h0ffffffc};
		f0 = (r0 >> 2) * 5;
		f1 = (r1 >> 2) + r1;
		f2 = (r2 >> 2) + r2;
		f3 = (r3 >> 2) + r3;
		f4 = r0 & 3;
		a0 = acc[0] + {32'b0, m[31:0]};
		a1 = acc[1] + {32'b0, m[63:32]};
		a2 = acc[2] + {32'b0, m[95:64]};
		a3 = acc[3] + {32'b0, m[127:96]};
		a4 = {32'b0, acc[4] + hibit};
		p0 = a0 * r0 + a1 * f3 + a2 * f2 + a3 * f1 + a4 * f0;
		p1 = a0 * r1 + a1 * r0 + a2 * f3 + a3 * f2 + a4 * f1;
		p2 = a0 * r2 + a1 * r1 + a2 * r0 + a3 * f3 + a4 * f2;
		p3 = a0 * r3 + a1 * r2 + a2 * r1 + a3 * r0 + a4 * f3;
		p4 = 32'(a4 * f4);
		top = p4 + p3[63:32];
		q0 = {32'b0, top >> 2} * 5 + {32'b0, p0[31:0]};
		q1 = (q0 >> 32) + {32'b0, p1[31:0]} + (p0 >> 32);
		q2 = (q1 >> 32) + {32'b0, p2[31:0]} + (p1 >> 32);
		q3 = (q2 >> 32) + {32'b0, p3[31:0]} + (p2 >> 32);
		q4 = q3[63:32] + (top & 3);
		acc[0] = q0[31:0];
		acc[1] = q1[31:0];
		acc[2] = q2[31:0];
		acc[3] = q3[31:0];
		acc[4] = q4;
	endfunction

	// full reduction plus s; clears the accumulator
	function automatic tag_word_t mac_finalize();
		logic [31:0] s [4];
		logic [31:0] t [4];
		logic [63:0] c;
		tag_word_t   w;
		s[0] = key_sl[31:0];
		s[1] = key_sl[63:32];
		s[2] = key_sh[31:0];
		s[3] = key_sh[63:32];
		c = 5;
		for (int i = 0; i < 4; i++) c = (c + acc[i]) >> 32;
		c = c + acc[4];
		c = (c >> 2) * 5;
		for (int i = 0; i < 4; i++) begin
			c = c + acc[i] + s[i];
			t[i] = c[31:0];
			c = c >> 32;
		end
		w.lo = {t[1], t[0]};
		w.hi = {t[3], t[2]};
		for (int i = 0; i < 5; i++) acc[i] = '0;
		return w;
	endfunction

	// predict one accepted word; returns 1 when a tag is expected
	function automatic bit mac_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
			logic last, output tag_word_t t);
		int           n;
		logic [127:0] m;
		n = (cnt > 16) ? 16 : cnt;
		m = {hi, lo};
		if (n > 0) begin
			if (n < 16) begin
				m = m & ((128'd1 << (8 * n)) - 1);
				m = m | (128'd1 << (8 * n));
			end
			mac_absorb(m, (n == 16) ? 32'd1 : 32'd0);
		end
		if (last) t = mac_finalize();
		return last;
	endfunction

	// valid stays high across back-to-back writes; load_key drops it after the last
	task automatic write_key(p1305_pkg::cfg_reg_t idx, logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			p1305_pkg::REG_R_LOW:  key_rl = val;
			p1305_pkg::REG_R_HIGH: key_rh = val;
			p1305_pkg::REG_S_LOW:  key_sl = val;
			default:               key_sh = val;
		endcase
	endtask

	task automatic load_key(logic [63:0] rl, rh, sl, sh);
		write_key(p1305_pkg::REG_R_LOW, rl);
		write_key(p1305_pkg::REG_R_HIGH, rh);
		write_key(p1305_pkg::REG_S_LOW, sl);
		write_key(p1305_pkg::REG_S_HIGH, sh);
		cfg_ch.valid <= 1'b0;
	endtask

	// send one word; when idle is set, drop valid for a random gap first, then hold it until the handshake
	task automatic send_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic last,
			bit idle);
		int        gap;
		tag_word_t t;
		gap = idle ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			blk_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_ch.valid      <= 1'b1;
		blk_ch.data_low   <= lo;
		blk_ch.data_high  <= hi;
		blk_ch.byte_count <= cnt;
		blk_ch.last_block <= last;
		do @(posedge clk); while (!blk_ch.ready);
		n_words++;
		if (mac_word(lo, hi, cnt, last, t)) pending_tags.push_back(t);
	endtask

	// drain outstanding tags, then let the datapath settle before touching the key
	task automatic wait_idle();
		blk_ch.valid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// tag sink: random stall per tag while sink_idle is set, compare against the oldest expected tag
	bit sink_idle = 1'b1;
	initial begin
		int gap;
		gap = 0;
		tag_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (tag_ch.valid && tag_ch.ready) begin
				n_tags++;
				if (pending_tags.size() == 0) begin
					$display("%0t: tag with none expected, actual %h_%h", $time,
						tag_ch.tag_high, tag_ch.tag_low);
					errors++;
				end else begin
					tag_word_t e;
					e = pending_tags.pop_front();
					if (e.lo !== tag_ch.tag_low) begin
						$display("%0t: tag_low expected %h actual %h", $time, e.lo,
							tag_ch.tag_low);
						errors++;
					end
					if (e.hi !== tag_ch.tag_high) begin
						$display("%0t: tag_high expected %h actual %h", $time, e.hi,
							tag_ch.tag_high);
						errors++;
					end
				end
				// draw the stall before the next tag
				gap = sink_idle ? $urandom_range(0, 13) : 0;
				if (gap != 0) tag_ch.ready <= 1'b0;
			end else if (!tag_ch.ready) begin
				// hold ready low until the drawn stall has counted down
				if (gap > 0) gap--;
				if (gap == 0) tag_ch.ready <= 1'b1;
			end
		end
	end

	// directed table; known tags only where trivially readable from the math
	blk_row_t dir_rows [] = '{
		// zero key, empty message: tag is s = 0
		'{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 64'h0, 64'h0},
		// zero r: any message collapses to s
		'{'1, '1, 5'd16, 1'b0, 1'b0, 64'h0, 64'h0},
		'{'1, '1, 5'd16, 1'b1, 1'b1, 64'h0, 64'h0},
		'{'1, '1, 5'd31, 1'b1, 1'b1, 64'h0, 64'h0}
	};

	// short ASCII message rows, checked by the predictor
	blk_row_t rfc_rows [] = '{
		'{64'h6172676f74707943, 64'h4620636968706172, 5'd16, 1'b0, 1'b0, 0, 0},
		'{64'h6863726165736552, 64'h6f7247206863, 5'd16, 1'b0, 1'b0, 0, 0},
		'{64'h7075, 64'h0, 5'd2, 1'b1, 1'b0, 0, 0}
	};

	initial begin
		int        ncnt;
		logic [4:0] c;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= p1305_pkg::REG_R_LOW;
		cfg_ch.data  <= '0;
		blk_ch.valid <= 1'b0;
		blk_ch.data_low <= '0;
		blk_ch.data_high <= '0;
		blk_ch.byte_count <= '0;
		blk_ch.last_block <= 1'b0;
		key_rl = '0; key_rh = '0; key_sl = '0; key_sh = '0;
		for (int i = 0; i < 5; i++) acc[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset key; typed tags replace the predictor's where given
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].cnt, dir_rows[i].last, 1'b0);
			if (dir_rows[i].known && dir_rows[i].last) begin
				pending_tags[$].lo = dir_rows[i].tlo;
				pending_tags[$].hi = dir_rows[i].thi;
			end
		end
		wait_idle();
		// all-ones key: clamp extremes, s wraps mod 2^128
		load_key('1, '1, '1, '1);
		send_word('1, '1, 5'd16, 1'b1, 1'b1);
		send_word('0, '0, 5'd0, 1'b0, 1'b1);   // empty middle word
		send_word('1, '1, 5'd7, 1'b0, 1'b1);   // short middle word
		send_word('1, '1, 5'd8, 1'b0, 1'b1);
		send_word('1, '1, 5'd15, 1'b1, 1'b1);
		send_word('1, '1, 5'd1, 1'b1, 1'b1);
		send_word('1, '1, 5'd0, 1'b1, 1'b1);
		wait_idle();
		load_key(64'h0103808afb0db2fd, 64'h4d4206a5be95f04b, 64'h4a5bf8060bbe07c5,
			64'h6a0e39a51bfe6cea);
		foreach (rfc_rows[i])
			send_word(rfc_rows[i].lo, rfc_rows[i].hi, rfc_rows[i].cnt, rfc_rows[i].last, 1'b1);
		// pause the sender until every tag has drained
		wait_idle();

		// random messages, several key phases; mostly well-formed, some noise
		for (int phase = 0; phase < 6; phase++) begin
			load_key(rnd64(), rnd64(), rnd64(), rnd64());
			sink_idle = (phase != 2);
			while (n_words < 230 * (phase + 1)) begin
				ncnt = $urandom_range(0, 5);
				for (int k = 0; k < ncnt; k++) begin
					c = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
					send_word(rnd64(), rnd64(), c, 1'b0, phase != 3);
				end
				c = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(0, 16));
				send_word(rnd64(), rnd64(), c, 1'b1, phase != 3);
			end
			wait_idle();
		end
		sink_idle = 1'b1;
		repeat (30) @(posedge clk);
		$display("Covered %0d message words and %0d tags over nine key settings.",
			n_words, n_tags);
		if (errors == 0 && pending_tags.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (pending_tags.size() != 0)
				$display("%0t: %0d expected tags never arrived", $time, pending_tags.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
